### rtl/core/uri_percent_decode_path_check_top_macros.svh
// ---------------------------------------------------------------------------
// URI path decoder assertion macros
// Shared concurrent assertion forms for the path decoder checkers.
// ---------------------------------------------------------------------------
`ifndef URI_PERCENT_DECODE_PATH_CHECK_TOP_MACROS_SVH
`define URI_PERCENT_DECODE_PATH_CHECK_TOP_MACROS_SVH

// Assertion that is switched off while reset is asserted
`define UPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("upd assertion failed");

// Assertion that is also checked during reset
`define UPD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("upd reset assertion failed");

`endif

### rtl/core/upd_pkg.sv
// ---------------------------------------------------------------------------
// URI path decoder package
// Constants, codes, types and helpers shared by the path decoder modules.
// ---------------------------------------------------------------------------
package upd_pkg;

  localparam int MaxPathLen = 512;
  localparam int CharW      = 8;
  localparam int CfgW       = 10;
  localparam int ErrW       = 3;
  localparam int CountW     = $clog2(MaxPathLen + 1);
  localparam int LimW       = (CountW > CfgW) ? CountW : CfgW;
  localparam int OutDataW   = 16;

  localparam logic [CfgW-1:0] PathLimitReset = CfgW'(512);

  // decoder phases
  localparam logic [2:0] PhSlash = 3'd0;
  localparam logic [2:0] PhCopy  = 3'd1;
  localparam logic [2:0] PhHi    = 3'd2;
  localparam logic [2:0] PhLo    = 3'd3;
  localparam logic [2:0] PhStop  = 3'd4;
  localparam logic [2:0] PhErr   = 3'd5;

  // segment kinds
  localparam logic [1:0] SegEmpty  = 2'd0;
  localparam logic [1:0] SegDot    = 2'd1;
  localparam logic [1:0] SegDotDot = 2'd2;
  localparam logic [1:0] SegOther  = 2'd3;

  // verdict codes
  localparam logic [ErrW-1:0] ErrNone    = 3'd0;
  localparam logic [ErrW-1:0] ErrNoSlash = 3'd1;
  localparam logic [ErrW-1:0] ErrEscape  = 3'd2;
  localparam logic [ErrW-1:0] ErrBadChar = 3'd3;
  localparam logic [ErrW-1:0] ErrTooLong = 3'd4;
  localparam logic [ErrW-1:0] ErrParent  = 3'd5;

  localparam logic [CharW-1:0] ChNul       = 8'h00;
  localparam logic [CharW-1:0] ChPercent   = 8'h25;
  localparam logic [CharW-1:0] ChQuery     = 8'h3F;
  localparam logic [CharW-1:0] ChHash      = 8'h23;
  localparam logic [CharW-1:0] ChBackslash = 8'h5C;
  localparam logic [CharW-1:0] ChDot       = 8'h2E;
  localparam logic [CharW-1:0] ChSlash     = 8'h2F;

  typedef struct packed {
    logic             is_end;
    logic [CharW-1:0] char_in;
  } upd_word_t;

  typedef struct packed {
    logic             ok;
    logic [3:0]       nibble;
  } upd_hex_t;

  function automatic upd_hex_t decode_hex(input logic [CharW-1:0] c);
    upd_hex_t r;
    r = '{ok: 1'b0, nibble: 4'd0};
    case (c) inside
      [8'h30:8'h39]: r = '{ok: 1'b1, nibble: 4'(c - 8'h30)};
      [8'h41:8'h46]: r = '{ok: 1'b1, nibble: 4'(c - 8'h41 + 8'd10)};
      [8'h61:8'h66]: r = '{ok: 1'b1, nibble: 4'(c - 8'h61 + 8'd10)};
      default:       r = '{ok: 1'b0, nibble: 4'd0};
    endcase
    return r;
  endfunction

endpackage

### rtl/core/upd_in_stage.sv
// ---------------------------------------------------------------------------
// URI path decoder input stage
// Registers one incoming word and holds it until the decoder takes it.
// ---------------------------------------------------------------------------
module upd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  upd_pkg::upd_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output upd_pkg::upd_word_t out_word_o
);
  import upd_pkg::*;

  logic      vld_q, vld_d;
  upd_word_t word_q;

  assign in_ready_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (in_ready_o) begin
      vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload: load on every accepted word
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= in_word_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_word_o  = word_q;

endmodule

### rtl/core/upd_core.sv
// ---------------------------------------------------------------------------
// URI path decoder core
// Percent decoding, path checks and the result register.
// ---------------------------------------------------------------------------
module upd_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [upd_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  upd_pkg::upd_word_t        in_word_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic                      res_is_verdict_o,
  output logic [upd_pkg::CharW-1:0] res_path_byte_o,
  output logic                      res_accepted_o,
  output logic [upd_pkg::ErrW-1:0]  res_error_code_o
);
  import upd_pkg::*;

  logic [2:0]        phase_q, phase_d;
  logic [3:0]        hi_q, hi_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [1:0]        seg_q, seg_d;
  logic [ErrW-1:0]   err_q, err_d;
  logic [CfgW-1:0]   lim_q;

  logic              out_vld_q, out_vld_d;
  logic              out_verdict_q;
  logic [CharW-1:0]  out_byte_q;
  logic              out_acc_q;
  logic [ErrW-1:0]   out_code_q;

  logic              take;
  logic              end_mark;
  upd_hex_t          hex;
  logic              dec_take;
  logic [CharW-1:0]  dec_byte;
  logic [LimW-1:0]   lim_eff;
  logic              emit, emit_verdict;
  logic [ErrW-1:0]   verdict_code;

  assign in_ready_o = !out_vld_q || res_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign end_mark   = in_word_i.is_end || (in_word_i.char_in == ChNul);
  assign hex        = decode_hex(in_word_i.char_in);
  assign lim_eff    = (LimW'(lim_q) < LimW'(MaxPathLen)) ? LimW'(lim_q) : LimW'(MaxPathLen);

  always_comb begin
    if (phase_q == PhErr) begin
      verdict_code = err_q;
    end else if (phase_q == PhSlash) begin
      verdict_code = ErrNoSlash;
    end else if (phase_q == PhHi || phase_q == PhLo) begin
      verdict_code = ErrEscape;
    end else if (seg_q == SegDotDot) begin
      verdict_code = ErrParent;
    end else begin
      verdict_code = ErrNone;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    hi_d         = hi_q;
    cnt_d        = cnt_q;
    seg_d        = seg_q;
    err_d        = err_q;
    emit         = 1'b0;
    emit_verdict = 1'b0;
    dec_take     = 1'b0;
    dec_byte     = in_word_i.char_in;

    if (take) begin
      if (end_mark) begin
        emit         = 1'b1;
        emit_verdict = 1'b1;
        phase_d      = PhSlash;
        hi_d         = 4'd0;
        cnt_d        = '0;
        seg_d        = SegEmpty;
        err_d        = ErrNone;
      end else begin
        case (phase_q)
          PhSlash: begin
            if (in_word_i.char_in == ChSlash) begin
              phase_d = PhCopy;
            end else begin
              phase_d = PhErr;
              err_d   = ErrNoSlash;
            end
          end
          PhCopy: begin
            if (in_word_i.char_in == ChQuery || in_word_i.char_in == ChHash) begin
              phase_d = PhStop;
            end else if (in_word_i.char_in == ChPercent) begin
              phase_d = PhHi;
            end else begin
              dec_take = 1'b1;
            end
          end
          PhHi: begin
            if (hex.ok) begin
              hi_d    = hex.nibble;
              phase_d = PhLo;
            end else begin
              phase_d = PhErr;
              err_d   = ErrEscape;
            end
          end
          PhLo: begin
            if (hex.ok) begin
              phase_d  = PhCopy;
              dec_take = 1'b1;
              dec_byte = {hi_q, hex.nibble};
            end else begin
              phase_d = PhErr;
              err_d   = ErrEscape;
            end
          end
          default: begin
          end
        endcase

        // checks on a decoded byte, in priority order
        if (dec_take) begin
          if (dec_byte == ChNul || dec_byte == ChBackslash) begin
            phase_d = PhErr;
            err_d   = ErrBadChar;
          end else if (LimW'(cnt_q) >= lim_eff) begin
            phase_d = PhErr;
            err_d   = ErrTooLong;
          end else if (dec_byte == ChSlash && seg_q == SegDotDot) begin
            phase_d = PhErr;
            err_d   = ErrParent;
          end else begin
            emit  = 1'b1;
            cnt_d = cnt_q + CountW'(1);
            if (dec_byte == ChSlash) begin
              seg_d = SegEmpty;
            end else if (dec_byte == ChDot) begin
              case (seg_q)
                SegEmpty: seg_d = SegDot;
                SegDot:   seg_d = SegDotDot;
                default:  seg_d = SegOther;
              endcase
            end else begin
              seg_d = SegOther;
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (res_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhSlash;
      hi_q      <= 4'd0;
      cnt_q     <= '0;
      seg_q     <= SegEmpty;
      err_q     <= ErrNone;
      lim_q     <= PathLimitReset;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      hi_q      <= hi_d;
      cnt_q     <= cnt_d;
      seg_q     <= seg_d;
      err_q     <= err_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i) begin
        lim_q <= cfg_data_i;
      end
    end
  end

  // result payload: load only when a new word is produced
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_verdict_q <= emit_verdict;
      out_byte_q    <= emit_verdict ? '0 : dec_byte;
      out_acc_q     <= emit_verdict && (verdict_code == ErrNone);
      out_code_q    <= emit_verdict ? verdict_code : ErrNone;
    end
  end

  assign res_valid_o      = out_vld_q;
  assign res_is_verdict_o = out_verdict_q;
  assign res_path_byte_o  = out_byte_q;
  assign res_accepted_o   = out_acc_q;
  assign res_error_code_o = out_code_q;

endmodule

### rtl/core/uri_percent_decode_path_check_top.sv
// ---------------------------------------------------------------------------
// URI path decoder and checker
// Percent-decodes a request path byte by byte and gives a verdict per URI.
// ---------------------------------------------------------------------------
// Input stream: one raw URI byte per word in s_axis_tdata; s_axis_tlast (or a
// zero byte) ends the URI. Output stream: m_axis_tuser low for a decoded path
// byte, high for the verdict word that closes each URI; tdata carries the
// byte, the accepted flag and the error code.
// Configuration: cfg_data_i sets the path limit when cfg_valid_i is high;
// cfg_ready_o is always high. Write it only between URIs.
// Path: an accepted word is registered in the input stage, decoded by the core
// and loaded into the result register, which drives the master side.
// Throughput: one word per cycle while the output is not stalled; the
// decoder updates all its state as each word is taken, so nothing limits
// the rate but the output handshake. Words that produce no result (leading
// slash, percent sign, first escape digit, query part, bytes after an error)
// are consumed without an output word.
// Stall: when m_axis_tready is low the result register holds and the input
// register fills; s_axis_tready then drops until the result is taken.
// Reset: clears all state, sets the path limit to 512 and empties both
// registers; the next byte is expected to be the leading slash.
module uri_percent_decode_path_check_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [upd_pkg::CfgW-1:0]        cfg_data_i,    // path_limit
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] char_in
  input  logic                            s_axis_tlast,  // is_end
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] path_byte, [8] accepted, [11:9] error_code, [15:12] zero
  output logic [upd_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                            m_axis_tuser   // is_verdict
);
  import upd_pkg::*;

  upd_word_t        in_word;
  upd_word_t        stage_word;
  logic             stage_valid;
  logic             core_ready;
  logic [CharW-1:0] path_byte;
  logic             accepted;
  logic [ErrW-1:0]  error_code;

  assign cfg_ready_o = 1'b1;
  assign in_word     = '{is_end: s_axis_tlast, char_in: s_axis_tdata};

  upd_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_word_i   (in_word),
    .out_valid_o (stage_valid),
    .out_ready_i (core_ready),
    .out_word_o  (stage_word)
  );

  upd_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (stage_valid),
    .in_ready_o       (core_ready),
    .in_word_i        (stage_word),
    .res_valid_o      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .res_is_verdict_o (m_axis_tuser),
    .res_path_byte_o  (path_byte),
    .res_accepted_o   (accepted),
    .res_error_code_o (error_code)
  );

  assign m_axis_tdata = {4'd0, error_code, accepted, path_byte};

endmodule

### rtl/core/upd_checker.sv
// ---------------------------------------------------------------------------
// URI path decoder port checker
// Watches the top-level ports of the path decoder over time.
// ---------------------------------------------------------------------------
`include "uri_percent_decode_path_check_top_macros.svh"

module upd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [upd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tuser
);
  import upd_pkg::*;

  logic              in_take;
  logic              out_stall;
  logic [OutDataW:0] out_word;
  logic              verdict_res;
  logic              byte_res;
  logic              verdict_ok;

  assign in_take     = s_axis_tvalid && s_axis_tready;
  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign out_word    = {m_axis_tuser, m_axis_tdata};
  assign verdict_res = m_axis_tvalid && m_axis_tuser;
  assign byte_res    = m_axis_tvalid && !m_axis_tuser;
  // accepted exactly when the code is clear, no path byte, code in range
  assign verdict_ok  = (m_axis_tdata[8] == (m_axis_tdata[11:9] == ErrNone)) &&
                       (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[11:9] <= ErrParent);

  // stalled result word holds
  `UPD_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid && $stable(out_word))

  `UPD_ASSERT(a_verdict_fields, clk_i, rst_ni, verdict_res |-> verdict_ok)

  // byte word carries no verdict
  `UPD_ASSERT(a_byte_fields, clk_i, rst_ni, byte_res |-> m_axis_tdata[15:8] == 8'd0)

  // a fresh result needs an input word taken earlier, through the input stage and the core
  `UPD_ASSERT(a_result_cause, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(in_take, 2))

  `UPD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid)

endmodule

bind uri_percent_decode_path_check_top upd_checker u_upd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// URI path decoder testbench
// Streams request URIs into the decoder, predicts every decoded byte and
// verdict in a scoreboard, and compares them with the master side word by
// word. The run moves through several path limits and idling settings.
// ---------------------------------------------------------------------------
module tb;
  import upd_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int HoldCycles   = 300;
  localparam int WordsPerStep = 150;
  localparam int QuietCycles  = 8;
  localparam int ReportMax    = 10;

  localparam logic [CharW-1:0] ChZero    = 8'h30;
  localparam logic [CharW-1:0] ChUpperA  = 8'h41;
  localparam logic [CharW-1:0] ChLowerA  = 8'h61;
  localparam logic [CharW-1:0] ChPlainLo = 8'h21;
  localparam logic [CharW-1:0] ChPlainHi = 8'h7E;

  typedef struct {
    bit              is_verdict;
    logic [7:0]      path_byte;
    bit              accepted;
    logic [ErrW-1:0] error_code;
  } path_result_t;

  class path_decode_board;
    logic [2:0]      phase;
    logic [3:0]      high_nib;
    int unsigned     decoded_len;
    logic [1:0]      seg_kind;
    logic [ErrW-1:0] held_err;
    logic [CfgW-1:0] path_limit;
    path_result_t    results_due[$];
    int              mismatches;
    int              bytes_seen;
    int              verdicts_seen;
    int              code_seen[8];

    function new();
      path_limit = PathLimitReset;
      mismatches = 0;
      bytes_seen = 0;
      verdicts_seen = 0;
      foreach (code_seen[k]) code_seen[k] = 0;
      start_uri();
    endfunction

    function void start_uri();
      phase = PhSlash;
      high_nib = '0;
      decoded_len = 0;
      seg_kind = SegEmpty;
      held_err = ErrNone;
    endfunction

    function void raise(input logic [ErrW-1:0] code);
      held_err = code;
      phase = PhErr;
    endfunction

    function void hex_nibble(input logic [7:0] c, output bit ok, output logic [3:0] n);
      ok = 1'b1;
      n = '0;
      if (c >= ChZero && c <= ChZero + 8'd9) n = 4'(c - ChZero);
      else if (c >= ChUpperA && c <= ChUpperA + 8'd5) n = 4'(c - ChUpperA + 8'd10);
      else if (c >= ChLowerA && c <= ChLowerA + 8'd5) n = 4'(c - ChLowerA + 8'd10);
      else ok = 1'b0;
    endfunction

    function void push_byte(input logic [7:0] b);
      int unsigned  lim;
      path_result_t r;
      lim = (path_limit < MaxPathLen) ? path_limit : MaxPathLen;
      // bad characters win over the length check
      if (b == ChNul || b == ChBackslash) begin
        raise(ErrBadChar);
        return;
      end
      if (decoded_len >= lim) begin
        raise(ErrTooLong);
        return;
      end
      if (b == ChSlash) begin
        if (seg_kind == SegDotDot) begin
          raise(ErrParent);
          return;
        end
        seg_kind = SegEmpty;
      end else if (b == ChDot) begin
        case (seg_kind)
          SegEmpty: seg_kind = SegDot;
          SegDot:   seg_kind = SegDotDot;
          default:  seg_kind = SegOther;
        endcase
      end else begin
        seg_kind = SegOther;
      end
      decoded_len++;
      r.is_verdict = 1'b0;
      r.path_byte = b;
      r.accepted = 1'b0;
      r.error_code = ErrNone;
      results_due.push_back(r);
    endfunction

    function void note_word(input logic [7:0] c, input logic last);
      bit              ok;
      logic [3:0]      n;
      logic [ErrW-1:0] code;
      path_result_t    r;
      if (last || c == ChNul) begin
        if (phase == PhErr) code = held_err;
        else if (phase == PhSlash) code = ErrNoSlash;
        else if (phase == PhHi || phase == PhLo) code = ErrEscape;
        else if (seg_kind == SegDotDot) code = ErrParent;
        else code = ErrNone;
        r.is_verdict = 1'b1;
        r.path_byte = '0;
        r.accepted = (code == ErrNone);
        r.error_code = code;
        results_due.push_back(r);
        start_uri();
        return;
      end
      case (phase)
        PhSlash: begin
          if (c == ChSlash) phase = PhCopy;
          else raise(ErrNoSlash);
        end
        PhCopy: begin
          if (c == ChQuery || c == ChHash) phase = PhStop;
          else if (c == ChPercent) phase = PhHi;
          else push_byte(c);
        end
        PhHi: begin
          hex_nibble(c, ok, n);
          if (!ok) begin
            raise(ErrEscape);
          end else begin
            high_nib = n;
            phase = PhLo;
          end
        end
        PhLo: begin
          hex_nibble(c, ok, n);
          if (!ok) begin
            raise(ErrEscape);
          end else begin
            phase = PhCopy;
            push_byte({high_nib, n});
          end
        end
        default: ;
      endcase
    endfunction

    function void check_word(input logic [OutDataW-1:0] data, input logic user);
      path_result_t e;
      bit           bad;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected word on master side: tuser=%0b tdata=%h", user, data);
        return;
      end
      e = results_due.pop_front();
      if (e.is_verdict) begin
        verdicts_seen++;
        code_seen[e.error_code]++;
      end else begin
        bytes_seen++;
      end
      bad = (user !== e.is_verdict) || (data[7:0] !== e.path_byte) ||
            (data[8] !== e.accepted) || (data[11:9] !== e.error_code) ||
            (data[15:12] !== 4'd0);
      if (bad) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display({"mismatch: expected verdict=%0b byte=%h acc=%0b code=%0d, ",
                    "got verdict=%0b byte=%h acc=%0b code=%0d upper=%h"},
                   e.is_verdict, e.path_byte, e.accepted, e.error_code,
                   user, data[7:0], data[8], data[11:9], data[15:12]);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgW-1:0]      cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;

  path_decode_board board;
  logic [7:0]       uri_bytes[$];
  int               words_sent = 0;
  int               cycle_count = 0;
  int               tx_idle_pct = 0;
  int               rx_stall_pct = 0;
  bit               hold_go = 1'b0;
  bit               hold_done = 1'b0;

  uri_percent_decode_path_check_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("cycle limit of %0d reached", CycleLimit);
      $display("simulation failed");
      $finish;
    end
  end

  // both handshakes are sampled on pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        board.note_word(s_axis_tdata, s_axis_tlast);
        words_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk_i) begin
    if (hold_go && !hold_done) m_axis_tready <= 1'b0;
    else m_axis_tready <= (int'($urandom_range(99)) >= rx_stall_pct);
  end

  // long receiver hold-off, counted here so the sender keeps pushing
  initial begin
    wait (hold_go);
    repeat (HoldCycles) @(posedge clk_i);
    hold_done = 1'b1;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return ChZero + 8'(n);
    return (($urandom_range(1) != 0) ? ChUpperA : ChLowerA) + 8'(n - 4'd10);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(ChPlainLo, ChPlainHi));
    while (c == ChPercent || c == ChQuery || c == ChHash || c == ChBackslash ||
           c == ChSlash || c == ChDot);
    return c;
  endfunction

  task automatic push_escape(input logic [7:0] b);
    uri_bytes.push_back(ChPercent);
    uri_bytes.push_back(hex_char(b[7:4]));
    uri_bytes.push_back(hex_char(b[3:0]));
  endtask

  task automatic fill_plain(input int count);
    uri_bytes.delete();
    uri_bytes.push_back(ChSlash);
    repeat (count) uri_bytes.push_back(($urandom_range(7) == 0) ? ChSlash : plain_char());
  endtask

  task automatic fill_uri(input int body_len, input bit noisy);
    logic [7:0] b;
    logic [3:0] n;
    bit         ok;
    int         pick;
    int         pos;
    uri_bytes.delete();
    uri_bytes.push_back(ChSlash);
    while (uri_bytes.size() <= body_len) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        uri_bytes.push_back(plain_char());
      end else if (pick < 70) begin
        uri_bytes.push_back(ChSlash);
      end else if (pick < 78) begin
        uri_bytes.push_back(ChDot);
      end else if (pick < 96) begin
        do b = 8'($urandom_range(1, 255)); while (b == ChBackslash);
        push_escape(b);
      end else begin
        // query or fragment: the rest is skipped up to the end marker
        uri_bytes.push_back(($urandom_range(1) != 0) ? ChQuery : ChHash);
        repeat ($urandom_range(4)) uri_bytes.push_back(8'($urandom_range(1, 255)));
      end
    end
    if (noisy) begin
      repeat ($urandom_range(1, 2)) begin
        pos = $urandom_range(uri_bytes.size() - 1);
        case ($urandom_range(6))
          0: uri_bytes[pos] = 8'($urandom_range(255));
          1: uri_bytes.insert(pos, ChBackslash);
          2: begin
            b = ($urandom_range(1) != 0) ? ChNul : ChBackslash;
            uri_bytes.insert(pos, hex_char(b[3:0]));
            uri_bytes.insert(pos, hex_char(b[7:4]));
            uri_bytes.insert(pos, ChPercent);
          end
          3: begin
            do begin
              b = 8'($urandom_range(255));
              board.hex_nibble(b, ok, n);
            end while (ok);
            uri_bytes.insert(pos, b);
            if ($urandom_range(1) != 0) uri_bytes.insert(pos, hex_char(4'($urandom_range(15))));
            uri_bytes.insert(pos, ChPercent);
          end
          4: uri_bytes[0] = 8'($urandom_range(255));
          5: begin
            // cut the URI off inside an escape
            uri_bytes.push_back(ChPercent);
            if ($urandom_range(1) != 0) uri_bytes.push_back(hex_char(4'($urandom_range(15))));
          end
          default: begin
            uri_bytes.insert(pos, ChSlash);
            uri_bytes.insert(pos, ChDot);
            uri_bytes.insert(pos, ChDot);
            uri_bytes.insert(pos, ChSlash);
          end
        endcase
      end
    end
  endtask

  // hold the word until taken, then idle at random
  task automatic send_word(input logic [7:0] c, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (int'($urandom_range(99)) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (int'($urandom_range(99)) < tx_idle_pct);
    end
  endtask

  task automatic send_uri();
    foreach (uri_bytes[k]) send_word(uri_bytes[k], 1'b0);
    if ($urandom_range(3) == 0) send_word(ChNul, 1'b0);
    else send_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    uri_bytes.delete();
    for (int k = 0; k < s.len(); k++) uri_bytes.push_back(s[k]);
    send_uri();
  endtask

  // drop valid and wait until every expected word is back and the block is quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.results_due.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CfgW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    board.path_limit = value;
  endtask

  initial begin
    int tx_modes[4];
    int rx_modes[4];
    int limits[6];
    int target;
    int lim;
    int len;
    tx_modes = '{0, 87, 0, 36};
    rx_modes = '{0, 0, 87, 36};
    limits = '{512, 1, 8, 700, 3, 100};
    board = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("");
    send_text("a");
    send_text("/%?");
    send_text("/%4");
    send_text("/%00");
    send_text("/\\");
    send_text("/..");
    send_text("/%2e.%2F");
    send_text("/%fF#z");
    send_text("/?x");

    for (int step = 0; step < 6; step++) begin
      settle();
      write_limit(CfgW'(limits[step]));
      tx_idle_pct = tx_modes[step % 4];
      rx_stall_pct = rx_modes[step % 4];
      lim = limits[step];
      if (step == 0) begin
        // fill the block while the receiver holds off
        hold_go = 1'b1;
        fill_plain(60);
        send_uri();
      end
      if (lim > MaxPathLen) begin
        // a limit above the cap: the byte after the cap is too long
        fill_plain(MaxPathLen + 1);
        send_uri();
      end
      target = words_sent + WordsPerStep;
      while (words_sent < target) begin
        if (lim <= 40 && $urandom_range(3) == 0) len = $urandom_range(lim - 1, lim + 3);
        else len = $urandom_range(12);
        fill_uri(len, $urandom_range(3) == 0);
        send_uri();
      end
    end

    settle();
    $display("covered %0d input words: %0d path bytes and %0d verdicts",
             words_sent, board.bytes_seen, board.verdicts_seen);
    $display({"limits 1 to 700, four idling mixes; verdicts by code: ok %0d, ",
              "no slash %0d, escape %0d, bad char %0d, too long %0d, parent %0d"},
             board.code_seen[ErrNone], board.code_seen[ErrNoSlash],
             board.code_seen[ErrEscape], board.code_seen[ErrBadChar],
             board.code_seen[ErrTooLong], board.code_seen[ErrParent]);
    if (board.mismatches == 0 && board.results_due.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
